// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error(msg);

// When the trigger is true, the check must be true in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, trig, chk, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (chk)) \
		else $error(msg);

`endif

// ===== rtl/wwr_pkg.sv =====
`default_nettype none
package wwr_pkg;

	localparam int WORD_MAX_DEF = 8;
	localparam int ITEM_Q_DEPTH = 2;
	localparam int OUT_Q_DEPTH  = 4;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;

	typedef enum logic [1:0] {
		REG_FIND_WORD      = 2'd0,
		REG_FIND_LENGTH    = 2'd1,
		REG_REPLACE_WORD   = 2'd2,
		REG_REPLACE_LENGTH = 2'd3
	} reg_index_t;

	// One text byte as it travels from the front to the back.
	typedef struct packed {
		logic [7:0] data;
		logic       tail;
		logic       letter;
	} item_t;

	// One byte of rewritten text.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [63:0] find_word;
		logic [3:0]  find_len;
		logic [63:0] replace_word;
		logic [3:0]  replace_len;
		logic        clear;
	} cfg_t;

	typedef struct packed {
		logic       idle;
		logic [3:0] win_count;
	} bk_status_t;

	function automatic logic is_letter(input logic [7:0] b);
		return ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) ||
		       ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z));
	endfunction

	function automatic logic [7:0] word_byte(input logic [63:0] w, input logic [2:0] i);
		return w[{i, 3'b000} +: 8];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/wwr_front.sv =====
`default_nettype none
module wwr_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire logic [7:0]    text_byte,
	input  wire logic          text_end,
	output wwr_pkg::item_t     item,
	output logic               item_valid,
	input  wire logic          item_take
);

	localparam int D  = wwr_pkg::ITEM_Q_DEPTH;
	localparam int PW = (D > 1) ? $clog2(D) : 1;
	localparam int CW = $clog2(D + 1);

	wwr_pkg::item_t q_q [D];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           acc;
	wwr_pkg::item_t in_item;

	assign full       = (cnt_q == CW'(D));
	assign item_valid = (cnt_q != '0);
	assign acc        = push && !full;
	assign item       = q_q[rd_ptr_q];

	// Letter class is worked out on entry so the back sees it ready.
	always_comb begin
		in_item.data   = text_byte;
		in_item.tail   = text_end;
		in_item.letter = wwr_pkg::is_letter(text_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (acc) begin
				wr_ptr_q <= (wr_ptr_q == PW'(D - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (item_take) begin
				rd_ptr_q <= (rd_ptr_q == PW'(D - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (acc && !item_take) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!acc && item_take) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			q_q[wr_ptr_q] <= in_item;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/wwr_back.sv =====
`default_nettype none
module wwr_back #(
	parameter int WORD_MAX = wwr_pkg::WORD_MAX_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire wwr_pkg::cfg_t   cfg,
	input  wire wwr_pkg::item_t  item,
	input  wire logic            item_valid,
	output logic                 item_take,
	output logic                 out_push,
	output wwr_pkg::out_item_t   out_item,
	input  wire logic            out_full,
	output wwr_pkg::bk_status_t  status
);

	localparam int DEPTH = WORD_MAX + 1;
	localparam int CW    = $clog2(WORD_MAX + 2);
	localparam int WIW   = $clog2(DEPTH);
	localparam int RW    = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_DECIDE = 4'b0010,
		ST_REPL   = 4'b0100,
		ST_FIN    = 4'b1000
	} bk_state_t;

	bk_state_t     state_q;
	logic [7:0]    win_q [DEPTH];
	logic          let_q [DEPTH];
	logic [CW-1:0] cnt_q;
	logic [RW-1:0] skip_q;
	logic [RW-1:0] idx_q;
	logic          prior_q;
	logic          end_q;
	logic          held_q;
	logic [7:0]    held_byte_q;

	logic [CW-1:0] flen;
	logic [CW-1:0] rlen;
	logic          eq_all;
	logic          hit;
	logic          skip_busy;
	logic          prod;
	logic [7:0]    pbyte;
	logic          need_push;
	logic          stall;
	logic          take_repl;

	function automatic bk_state_t after_state(input logic fl, input logic [CW-1:0] c);
		if (!fl) begin
			return ST_IDLE;
		end
		return (c != '0) ? ST_DECIDE : ST_FIN;
	endfunction

	always_comb begin
		if (cfg.find_len == 4'd0) begin
			flen = CW'(1);
		end else if (cfg.find_len > 4'(WORD_MAX)) begin
			flen = CW'(WORD_MAX);
		end else begin
			flen = CW'(cfg.find_len);
		end
		rlen = (cfg.replace_len > 4'(WORD_MAX)) ? CW'(WORD_MAX) : CW'(cfg.replace_len);
	end

	always_comb begin
		eq_all = 1'b1;
		for (int i = 0; i < WORD_MAX; i++) begin
			if ((CW'(i) < flen) && (win_q[i] != wwr_pkg::word_byte(cfg.find_word, 3'(i)))) begin
				eq_all = 1'b0;
			end
		end
		hit = (cnt_q >= flen) && !prior_q && eq_all &&
		      !((cnt_q > flen) && let_q[flen[WIW-1:0]]);
	end

	assign skip_busy = (skip_q != '0);
	assign take_repl = !skip_busy && hit && (rlen != '0);

	always_comb begin
		prod  = 1'b0;
		pbyte = win_q[0];
		case (state_q)
			ST_DECIDE: begin
				prod = !skip_busy && !hit;
			end
			ST_REPL: begin
				prod  = 1'b1;
				pbyte = wwr_pkg::word_byte(cfg.replace_word, 3'(idx_q));
			end
			default: begin
				prod = 1'b0;
			end
		endcase
	end

	// While the window is being flushed, one byte is held back so the final one can be marked.
	always_comb begin
		if (state_q == ST_FIN) begin
			need_push = held_q;
		end else begin
			need_push = prod && (!end_q || held_q);
		end
		stall         = need_push && out_full;
		out_push      = need_push && !out_full;
		out_item.data = ((state_q == ST_FIN) || end_q) ? held_byte_q : pbyte;
		out_item.last = (state_q == ST_FIN);
	end

	assign item_take = (state_q == ST_IDLE) && item_valid && !cfg.clear;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			skip_q  <= '0;
			idx_q   <= '0;
			prior_q <= 1'b0;
			end_q   <= 1'b0;
			held_q  <= 1'b0;
		end else if (cfg.clear) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			skip_q  <= '0;
			idx_q   <= '0;
			prior_q <= 1'b0;
			end_q   <= 1'b0;
			held_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						cnt_q <= cnt_q + 1'b1;
						end_q <= item.tail;
						if (item.tail || (cnt_q == flen)) begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					if (!stall) begin
						prior_q <= let_q[0];
						cnt_q   <= cnt_q - 1'b1;
						if (skip_busy) begin
							skip_q <= skip_q - 1'b1;
						end else if (hit) begin
							skip_q <= RW'(flen - 1'b1);
						end
						if (take_repl) begin
							state_q <= ST_REPL;
							idx_q   <= '0;
						end else begin
							state_q <= after_state(end_q, cnt_q - 1'b1);
						end
						if (prod && end_q) begin
							held_q <= 1'b1;
						end
					end
				end
				ST_REPL: begin
					if (!stall) begin
						if (idx_q == RW'(rlen - 1'b1)) begin
							state_q <= after_state(end_q, cnt_q);
						end else begin
							idx_q <= idx_q + 1'b1;
						end
						if (end_q) begin
							held_q <= 1'b1;
						end
					end
				end
				ST_FIN: begin
					if (!stall) begin
						state_q <= ST_IDLE;
						cnt_q   <= '0;
						skip_q  <= '0;
						prior_q <= 1'b0;
						end_q   <= 1'b0;
						held_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			win_q[cnt_q[WIW-1:0]] <= item.data;
			let_q[cnt_q[WIW-1:0]] <= item.letter;
		end else if ((state_q == ST_DECIDE) && !stall) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				win_q[i] <= win_q[i + 1];
				let_q[i] <= let_q[i + 1];
			end
		end
		if (!stall && prod && end_q) begin
			held_byte_q <= pbyte;
		end
	end

	assign status.idle      = (state_q == ST_IDLE);
	assign status.win_count = 4'(cnt_q);

endmodule
`default_nettype wire

// ===== rtl/wwr_out_fifo.sv =====
`default_nettype none
module wwr_out_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_en,
	input  wire wwr_pkg::out_item_t  wr_data,
	output logic                     full,
	output logic                     empty,
	input  wire logic                pop,
	output logic [7:0]               out_byte,
	output logic                     out_last
);

	localparam int D  = wwr_pkg::OUT_Q_DEPTH;
	localparam int PW = (D > 1) ? $clog2(D) : 1;
	localparam int CW = $clog2(D + 1);

	wwr_pkg::out_item_t q_q [D];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [CW-1:0]      cnt_q;
	logic               wr;
	logic               rd;

	assign full     = (cnt_q == CW'(D));
	assign empty    = (cnt_q == '0);
	assign wr       = wr_en && !full;
	assign rd       = pop && !empty;
	assign out_byte = q_q[rd_ptr_q].data;
	assign out_last = q_q[rd_ptr_q].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(D - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(D - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!wr && rd) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			q_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/whole_word_replace_stream.sv =====
// A byte is decided once the find length of later bytes has arrived, or at text end; its
// result is then written into the output queue. The back takes one byte per cycle while the
// window fills, then takes and decides each byte in turn; a replacement writes its bytes one
// after another, and text end adds a decide step per held byte plus a final step for the last
// byte. Writes wait while the output queue is full. Reset (arst_n low) empties both queues and
// the window, loads find_length 1 and clears the other configuration registers.
`default_nettype none
`include "assert_macros.svh"
module whole_word_replace_stream #(
	parameter int WORD_MAX = wwr_pkg::WORD_MAX_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  text_byte,
	input  wire logic        text_end,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       out_byte,
	output logic             out_last,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	// Configuration registers. A write to the search length also starts a new text, so the
	// back part gets a clear pulse in the same cycle.
	logic [63:0] find_word_q;
	logic [3:0]  find_length_q;
	logic [63:0] replace_word_q;
	logic [3:0]  replace_length_q;

	wwr_pkg::cfg_t       cfg;
	wwr_pkg::item_t      item;
	logic                item_valid;
	logic                item_take;
	logic                bo_push;
	wwr_pkg::out_item_t  bo_item;
	logic                bo_full;
	wwr_pkg::bk_status_t bk_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			find_word_q      <= '0;
			find_length_q    <= 4'd1;
			replace_word_q   <= '0;
			replace_length_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				wwr_pkg::REG_FIND_WORD: begin
					find_word_q <= cfg_data;
				end
				wwr_pkg::REG_FIND_LENGTH: begin
					find_length_q <= cfg_data[3:0];
				end
				wwr_pkg::REG_REPLACE_WORD: begin
					replace_word_q <= cfg_data;
				end
				wwr_pkg::REG_REPLACE_LENGTH: begin
					replace_length_q <= cfg_data[3:0];
				end
				default: begin
					find_word_q <= find_word_q;
				end
			endcase
		end
	end

	always_comb begin
		cfg.find_word    = find_word_q;
		cfg.find_len     = find_length_q;
		cfg.replace_word = replace_word_q;
		cfg.replace_len  = replace_length_q;
		cfg.clear        = cfg_we && (cfg_index == wwr_pkg::REG_FIND_LENGTH);
	end

	// Front: takes input transactions, tags each byte with its letter class and queues it.
	wwr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.text_byte  (text_byte),
		.text_end   (text_end),
		.item       (item),
		.item_valid (item_valid),
		.item_take  (item_take)
	);

	// Back: holds the lookahead window, decides the head byte, and writes either the byte
	// itself, the replacement word, or nothing while matched bytes are skipped.
	wwr_back #(
		.WORD_MAX (WORD_MAX)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item       (item),
		.item_valid (item_valid),
		.item_take  (item_take),
		.out_push   (bo_push),
		.out_item   (bo_item),
		.out_full   (bo_full),
		.status     (bk_stat)
	);

	// Result queue: the back keeps working while finished bytes wait to be popped, until the queue is full.
	wwr_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (bo_push),
		.wr_data  (bo_item),
		.full     (bo_full),
		.empty    (empty),
		.pop      (pop),
		.out_byte (out_byte),
		.out_last (out_last)
	);

	`ASSERT_NEVER(a_push_when_full, clk, arst_n, bo_push && bo_full, "back wrote a full result queue")
	`ASSERT_NEVER(a_take_no_item, clk, arst_n, item_take && !item_valid, "back took a missing item")
	`ASSERT_NEVER(a_window_bound, clk, arst_n, bk_stat.win_count > 4'(WORD_MAX + 1), "window overflow")
	`ASSERT_NEXT(a_clear_window, clk, arst_n, cfg.clear, bk_stat.idle && (bk_stat.win_count == 4'd0), "length write did not clear the window")

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;

	// Scoreboard for the rewritten text. It keeps its own copy of the block's registers and
	// lookahead window. For every byte transaction taken on the input side, it works out the
	// bytes that the block must give back. For every output transaction, it compares the byte
	// with the oldest one still waiting.
	class text_rewrite_model;
		logic [63:0]        find_word;
		logic [3:0]         find_len;
		logic [63:0]        repl_word;
		logic [3:0]         repl_len;
		logic [7:0]         held[0:wwr_pkg::WORD_MAX_DEF];
		int                 held_cnt;
		int                 drop_cnt;
		bit                 prev_alpha;
		int                 step_emits;
		int                 error_count;
		wwr_pkg::out_item_t expected_bytes[$];

		function new();
			find_word = '0;
			find_len = 4'd1;
			repl_word = '0;
			repl_len = '0;
			foreach (held[i]) held[i] = '0;
			error_count = 0;
			restart();
		endfunction

		static function bit is_alpha(logic [7:0] b);
			return (b >= wwr_pkg::CH_UPPER_A && b <= wwr_pkg::CH_UPPER_Z) ||
			       (b >= wwr_pkg::CH_LOWER_A && b <= wwr_pkg::CH_LOWER_Z);
		endfunction

		static function logic [7:0] word_at(logic [63:0] w, int i);
			return w[8 * (i % 8) +: 8];
		endfunction

		function int find_span();
			if (find_len == 0)
				return 1;
			return (find_len > wwr_pkg::WORD_MAX_DEF) ? wwr_pkg::WORD_MAX_DEF : int'(find_len);
		endfunction

		function int repl_span();
			return (repl_len > wwr_pkg::WORD_MAX_DEF) ? wwr_pkg::WORD_MAX_DEF : int'(repl_len);
		endfunction

		function void restart();
			held_cnt = 0;
			drop_cnt = 0;
			prev_alpha = 1'b0;
		endfunction

		function void apply_reg(wwr_pkg::reg_index_t idx, logic [63:0] val);
			case (idx)
				wwr_pkg::REG_FIND_WORD: find_word = val;
				wwr_pkg::REG_FIND_LENGTH: begin
					// A new search length throws away whatever the window holds.
					find_len = val[3:0];
					restart();
				end
				wwr_pkg::REG_REPLACE_WORD: repl_word = val;
				wwr_pkg::REG_REPLACE_LENGTH: repl_len = val[3:0];
				default: ;
			endcase
		endfunction

		function void emit(logic [7:0] b);
			wwr_pkg::out_item_t item;
			item.data = b;
			item.last = 1'b0;
			expected_bytes.push_back(item);
			step_emits++;
		endfunction

		// Decides the byte at the head of the window, then shifts the window by one.
		function void decide_head();
			int l;
			int r;
			int i;
			bit hit;
			logic [7:0] head;
			l = find_span();
			head = held[0];
			if (drop_cnt > 0) begin
				drop_cnt--;
			end else begin
				hit = (held_cnt >= l) && !prev_alpha;
				for (i = 0; i < l; i++)
					if (held[i] != word_at(find_word, i))
						hit = 1'b0;
				// A letter right after the candidate makes it part of a longer word.
				if (hit && held_cnt > l && is_alpha(held[l]))
					hit = 1'b0;
				if (hit) begin
					r = repl_span();
					for (i = 0; i < r; i++)
						emit(word_at(repl_word, i));
					drop_cnt = l - 1;
				end else begin
					emit(head);
				end
			end
			// The byte before the next candidate is the real input byte, replaced or not.
			prev_alpha = is_alpha(head);
			for (i = 1; i < held_cnt && i <= wwr_pkg::WORD_MAX_DEF; i++)
				held[i - 1] = held[i];
			held_cnt--;
		endfunction

		function void take_byte(logic [7:0] b, logic e);
			int l;
			wwr_pkg::out_item_t tail;
			l = find_span();
			step_emits = 0;
			while (held_cnt >= l + 1)
				decide_head();
			held[held_cnt] = b;
			held_cnt++;
			if (e) begin
				while (held_cnt > 0)
					decide_head();
				// When the whole flush produced nothing, no byte carries the last flag.
				if (step_emits > 0) begin
					tail = expected_bytes.pop_back();
					tail.last = 1'b1;
					expected_bytes.push_back(tail);
				end
				restart();
			end else begin
				while (held_cnt >= l + 1)
					decide_head();
			end
		endfunction

		task report(string msg);
			if (error_count < 50)
				$display("%0t ns: mismatch: %s", $time, msg);
			error_count++;
		endtask

		task check_byte(logic [7:0] b, logic last);
			wwr_pkg::out_item_t want;
			if (expected_bytes.size() == 0) begin
				report($sformatf("byte %02h last %0b with nothing waiting", b, last));
				return;
			end
			want = expected_bytes.pop_front();
			if (b !== want.data)
				report($sformatf("out_byte %02h, wanted %02h", b, want.data));
			if (last !== want.last)
				report($sformatf("out_last %0b on byte %02h, wanted %0b", last, b, want.last));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  text_byte;
	logic        text_end;
	logic        empty;
	logic        pop;
	logic [7:0]  out_byte;
	logic        out_last;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	text_rewrite_model rewriter = new();

	// Bookkeeping for the stimulus side.
	int          items_sent;
	bit          src_idle_on;
	bit          snk_idle_on;
	logic [63:0] cur_find_word;
	int          cur_find_span;

	whole_word_replace_stream dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.text_byte (text_byte),
		.text_end  (text_end),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Everything the testbench drives changes on the falling edge, so at the rising edge the
	// monitor below sees settled inputs and the block's outputs from before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				rewriter.apply_reg(wwr_pkg::reg_index_t'(cfg_index), cfg_data);
			if (push && !full)
				rewriter.take_byte(text_byte, text_end);
			if (pop && !empty)
				rewriter.check_byte(out_byte, out_last);
		end
	end

	// Output side. While stalls are enabled, the pop line now and then stalls for a random burst.
	initial begin : pop_driver
		int hold;
		hold = 0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				pop <= 1'b0;
				hold--;
			end else if (snk_idle_on && $urandom_range(0, 9) == 0) begin
				hold = $urandom_range(1, 14) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Offers one byte and returns once the block has taken the transaction. While idling is
	// enabled, an occasional gap of random length goes in front of the byte. Push stays high
	// from one byte to the next when there is no gap.
	task automatic send_byte(input logic [7:0] b, input logic e);
		int gap;
		gap = 0;
		if (src_idle_on && $urandom_range(0, 7) == 0)
			gap = $urandom_range(1, 14);
		if (gap > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		text_byte <= b;
		text_end <= e;
		@(posedge clk);
		while (full)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_string(input string s, input bit closed);
		int i;
		for (i = 0; i < s.len(); i++)
			send_byte(s[i], closed && (i == s.len() - 1));
	endtask

	// Stops the input side and waits until every byte the scoreboard predicted has come out.
	// Bytes that only sit in the window produce nothing, so a further wait after that lets any
	// work still in the pipeline finish before a register is touched.
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (rewriter.expected_bytes.size() != 0)
			@(posedge clk);
		repeat (48) @(posedge clk);
	endtask

	task automatic load_reg(input wwr_pkg::reg_index_t idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic [63:0] fw, input logic [3:0] fl,
			input logic [63:0] rw, input logic [3:0] rl);
		settle();
		load_reg(wwr_pkg::REG_FIND_WORD, fw);
		load_reg(wwr_pkg::REG_FIND_LENGTH, {60'd0, fl});
		load_reg(wwr_pkg::REG_REPLACE_WORD, rw);
		load_reg(wwr_pkg::REG_REPLACE_LENGTH, {60'd0, rl});
		cur_find_word = fw;
		cur_find_span = (fl == 0) ? 1 :
			(fl > wwr_pkg::WORD_MAX_DEF) ? wwr_pkg::WORD_MAX_DEF : int'(fl);
	endtask

	function automatic logic [63:0] pack_word(input string s);
		logic [63:0] w;
		int i;
		w = '0;
		for (i = 0; i < s.len() && i < 8; i++)
			w[8 * i +: 8] = s[i];
		return w;
	endfunction

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(0, 1) == 0)
			return wwr_pkg::CH_UPPER_A + 8'($urandom_range(0, 25));
		return wwr_pkg::CH_LOWER_A + 8'($urandom_range(0, 25));
	endfunction

	// Non-letters that tend to border words, including the bytes right next to both letter
	// ranges.
	function automatic logic [7:0] rand_border();
		string marks;
		marks = " ,.;:!?-_09\t\n@[`{";
		return marks[$urandom_range(0, marks.len() - 1)];
	endfunction

	// A search word made mostly of letters so that random text can actually hit it.
	function automatic logic [63:0] rand_word();
		logic [63:0] w;
		int j;
		int r;
		for (j = 0; j < 8; j++) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				w[8 * j +: 8] = rand_letter();
			else if (r < 85)
				w[8 * j +: 8] = rand_border();
			else
				w[8 * j +: 8] = 8'($urandom_range(0, 255));
		end
		return w;
	endfunction

	// Builds one text out of pieces: whole occurrences of the search word, borders, plain
	// letters, cut-off or glued-on occurrences, and arbitrary bytes. The text ends with the
	// end flag when closed is set; otherwise it stays open for the next phase.
	task automatic send_random_text(input bit closed);
		logic [7:0] text_q[$];
		int pieces;
		int k;
		int j;
		int n;
		int kind;
		pieces = $urandom_range(1, 8);
		for (k = 0; k < pieces; k++) begin
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				for (j = 0; j < cur_find_span; j++)
					text_q.push_back(cur_find_word[8 * j +: 8]);
			end else if (kind < 55) begin
				text_q.push_back(rand_border());
			end else if (kind < 68) begin
				n = $urandom_range(1, 3);
				repeat (n) text_q.push_back(rand_letter());
			end else if (kind < 78) begin
				// A prefix of the word, or the whole word with a letter glued to its end.
				n = $urandom_range(1, cur_find_span);
				for (j = 0; j < n; j++)
					text_q.push_back(cur_find_word[8 * j +: 8]);
				if (n == cur_find_span)
					text_q.push_back(rand_letter());
			end else if (kind < 90) begin
				text_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				// A letter glued to the front of the word.
				text_q.push_back(rand_letter());
				for (j = 0; j < cur_find_span; j++)
					text_q.push_back(cur_find_word[8 * j +: 8]);
			end
		end
		for (j = 0; j < text_q.size(); j++)
			send_byte(text_q[j], closed && (j == text_q.size() - 1));
	endtask

	initial begin : stimulus
		int phase;
		int texts;
		int t;
		logic [3:0] fl;
		logic [3:0] rl;

		arst_n = 1'b0;
		push = 1'b0;
		text_byte = '0;
		text_end = 1'b0;
		cfg_we = 1'b0;
		cfg_index = wwr_pkg::REG_FIND_WORD;
		cfg_data = '0;
		items_sent = 0;
		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;
		cur_find_word = '0;
		cur_find_span = 1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed texts. The first one has a word at the very start of the text, then a word
		// after a comma that is rejected because a letter follows it.
		configure(pack_word("cat"), 4'd3, pack_word("tiger"), 4'd5);
		send_string("cat,cats", 1'b1);
		// Both extreme byte values pass through untouched.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);

		// Rewriting the search length while the window holds bytes drops those bytes and
		// starts a fresh text.
		send_string("ca", 1'b0);
		settle();
		load_reg(wwr_pkg::REG_FIND_LENGTH, 64'd3);
		send_string("t", 1'b1);

		// The whole text is replaced by an empty word, so no byte can carry the last flag.
		settle();
		load_reg(wwr_pkg::REG_REPLACE_LENGTH, 64'd0);
		send_string("cat", 1'b1);

		// Out-of-range lengths: a search length of zero counts as one, and lengths above the
		// maximum count as the maximum.
		configure(pack_word("A"), 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
		send_string("A", 1'b1);
		configure(pack_word("ABCDEFGH"), 4'd15, 64'h0, 4'd8);
		send_string("ABCDEFGH", 1'b1);

		// Random phases. Every phase reloads all four registers once the block is idle; the
		// first three pin down the extremes of the word and length settings. The last text of
		// a phase is sometimes left open, so the next phase's length write cuts into it.
		phase = 0;
		while (items_sent < 480) begin
			if (items_sent >= 420) begin
				src_idle_on = 1'b0;
				snk_idle_on = 1'b0;
			end else begin
				src_idle_on = ($urandom_range(0, 3) != 0);
				snk_idle_on = ($urandom_range(0, 3) != 0);
			end
			fl = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
			rl = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
			case (phase)
				0: configure(64'h0, 4'd1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
				1: configure(rand_word(), 4'd8, 64'h0, 4'd0);
				2: configure(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, rand_word(), 4'd1);
				default: configure(rand_word(), fl, {$urandom, $urandom}, rl);
			endcase
			texts = $urandom_range(2, 6);
			for (t = 0; t < texts && items_sent < 480; t++) begin
				// The tail of the run goes at full speed on both sides.
				if (items_sent >= 420) begin
					src_idle_on = 1'b0;
					snk_idle_on = 1'b0;
				end
				send_random_text((t < texts - 1) || ($urandom_range(0, 4) != 0));
			end
			phase++;
		end

		// Wait for the last expected bytes, then give the pipeline time to show stray output.
		settle();
		if (rewriter.error_count == 0) begin
			$display("PASS whole_word_replace_stream");
		end else begin
			$display("FAIL whole_word_replace_stream");
		end
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin : watchdog
		#30_000_000;
		$display("FAIL whole_word_replace_stream");
		$finish;
	end

endmodule
